[hw/rtl/atws_pkg.sv]
// shared constants, codes and interface types of the triangle wave synthesizer
`timescale 1ns / 1ps

package atws_pkg;

  // parameter defaults
  localparam int MAX_HARMONICS_DEF  = 512;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF    = 24;

  // fixed field widths
  localparam int AMP_W      = 16;
  localparam int PHASE_W    = 32;
  localparam int HCOUNT_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // quarter-wave entries are Q1.30, at most 1.0
  localparam int SINE_W = 31;

  // gain times sine, and the shift that lands it on output lsbs plus guard bits
  localparam int PROD_W          = AMP_W + SINE_W;
  localparam int TERM_SHIFT_BASE = 39;
  localparam int GUARD_BITS      = 8;

  // register reset values
  localparam logic [AMP_W-1:0]    AMP_RESET    = 16'd16384;
  localparam logic [PHASE_W-1:0]  STEP_RESET   = 32'd38956620;
  localparam logic [HCOUNT_W-1:0] HCOUNT_RESET = 10'd501;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE      = 2'd0,
    CFG_PHASE_STEP     = 2'd1,
    CFG_HARMONIC_COUNT = 2'd2
  } cfg_reg_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic terms_left;
    logic pipe_busy;
  } dp_status_t;

endpackage

[hw/rtl/atws_sine_rom.sv]
// quarter-wave sine rom, filled at start-up, registered read
`timescale 1ns / 1ps

module atws_sine_rom #(
  parameter int ADDR_BITS = atws_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic [ADDR_BITS:0]          rd_addr,
  output logic [atws_pkg::SINE_W-1:0] rd_data
);

  localparam int DEPTH = (1 << ADDR_BITS) + 1;
  localparam int SW    = atws_pkg::SINE_W;

  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  logic [SW-1:0] sine_rom [DEPTH];
  logic [SW-1:0] rd_data_r;

  // one entry: taylor series of sin in q30, inner terms first
  function automatic logic [SW-1:0] quarter_sine(input int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] s;
    x  = ((HALF_PI_Q60 >> 16) * 64'(j)) >> (ADDR_BITS + 14);
    x2 = (x * x) >> 30;
    r  = Q30_ONE;
    t  = ((x2 * r) >> 30) / 64'd210;
    r  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * r) >> 30) / 64'd156;
    r  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * r) >> 30) / 64'd110;
    r  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * r) >> 30) / 64'd72;
    r  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * r) >> 30) / 64'd42;
    r  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * r) >> 30) / 64'd20;
    r  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    t  = ((x2 * r) >> 30) / 64'd6;
    r  = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    s  = (x * r) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    return s[SW-1:0];
  endfunction

  // rom contents
  initial begin
    for (int j = 0; j < DEPTH; j++) begin
      sine_rom[j] = quarter_sine(j);
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= sine_rom[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/atws_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module atws_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] in_dvd,
  input  logic [DVS_W-1:0] in_dvs,
  input  logic             in_neg,
  output logic             out_valid,
  output logic [DVD_W-1:0] out_quo,
  output logic             out_neg,
  output logic             busy
);

  logic             st_v_r   [1:DVD_W];
  logic [DVD_W-1:0] st_n_r   [1:DVD_W];
  logic [DVD_W-1:0] st_q_r   [1:DVD_W];
  logic [DVS_W-1:0] st_rem_r [1:DVD_W];
  logic [DVS_W-1:0] st_d_r   [1:DVD_W];
  logic             st_neg_r [1:DVD_W];

  for (genvar s = 1; s <= DVD_W; s++) begin : g_stage
    logic             src_v;
    logic [DVD_W-1:0] src_n;
    logic [DVD_W-1:0] src_q;
    logic [DVS_W-1:0] src_rem;
    logic [DVS_W-1:0] src_d;
    logic             src_neg;
    logic [DVS_W:0]   trial;
    logic             fit;

    // stage source: divider inputs or previous stage
    if (s == 1) begin : g_first
      assign src_v   = in_valid;
      assign src_n   = in_dvd;
      assign src_q   = '0;
      assign src_rem = '0;
      assign src_d   = in_dvs;
      assign src_neg = in_neg;
    end else begin : g_next
      assign src_v   = st_v_r[s-1];
      assign src_n   = st_n_r[s-1];
      assign src_q   = st_q_r[s-1];
      assign src_rem = st_rem_r[s-1];
      assign src_d   = st_d_r[s-1];
      assign src_neg = st_neg_r[s-1];
    end

    // bring down next dividend bit, subtract if it fits
    assign trial = {src_rem, src_n[DVD_W-1]};
    assign fit   = (trial >= {1'b0, src_d});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[s] <= 1'b0;
      end else begin
        st_v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      st_n_r[s]   <= src_n << 1;
      st_q_r[s]   <= {src_q[DVD_W-2:0], fit};
      st_rem_r[s] <= fit ? DVS_W'(trial - {1'b0, src_d}) : trial[DVS_W-1:0];
      st_d_r[s]   <= src_d;
      st_neg_r[s] <= src_neg;
    end
  end

  // any item in flight
  always_comb begin
    busy = 1'b0;
    for (int s = 1; s <= DVD_W; s++) begin
      busy = busy | st_v_r[s];
    end
  end

  assign out_valid = st_v_r[DVD_W];
  assign out_quo   = st_q_r[DVD_W];
  assign out_neg   = st_neg_r[DVD_W];

endmodule

[hw/rtl/atws_datapath.sv]
// datapath: registers, phase accumulator, term pipeline, accumulator, output stage
`timescale 1ns / 1ps

module atws_datapath #(
  parameter int MAX_H     = atws_pkg::MAX_HARMONICS_DEF,
  parameter int ADDR_BITS = atws_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_W  = atws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [atws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atws_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_restart,
  input  atws_pkg::dp_cmd_t               cmd,
  output atws_pkg::dp_status_t            status,
  output logic signed [SAMPLE_W-1:0]      out_sample,
  output logic                            out_clipped
);

  localparam int AW_   = atws_pkg::AMP_W;
  localparam int PW    = atws_pkg::PHASE_W;
  localparam int HCW   = atws_pkg::HCOUNT_W;
  localparam int SNW   = atws_pkg::SINE_W;
  localparam int PRW   = atws_pkg::PROD_W;
  localparam int GB    = atws_pkg::GUARD_BITS;
  localparam int IW    = $clog2(2 * MAX_H);
  localparam int SQW   = 2 * IW;
  localparam int SHIFT = atws_pkg::TERM_SHIFT_BASE - SAMPLE_W;
  localparam int DW    = PRW - SHIFT;
  localparam int ACW   = DW + 2;
  localparam int ACW1  = ACW + 1;
  localparam int RW    = ACW1 - GB;

  localparam logic [ADDR_BITS:0] QUARTER    = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [ACW:0]       ROUND_HALF = ACW1'(1) << (GB - 1);
  localparam logic [RW-1:0]      POS_LIM    = RW'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic [RW-1:0]      NEG_LIM    = RW'(64'd1 << (SAMPLE_W - 1));
  localparam logic [SAMPLE_W-1:0] SAT_MAX   = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_MIN   = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  logic [AW_-1:0]      amplitude_r;
  logic [PW-1:0]       phase_step_r;
  logic [HCW-1:0]      harmonic_count_r;
  logic [PW-1:0]       base_phase_r;
  logic [PW-1:0]       start_phase;
  logic [HCW-1:0]      count_clamp;
  logic [HCW-1:0]      rem_r;
  logic [PW-1:0]       hp_r;
  logic [PW-1:0]       step2_r;
  logic [IW-1:0]       i_r;
  logic [SQW-1:0]      sq_r;
  logic                kodd_r;
  logic [ADDR_BITS-1:0] rom_j;
  logic [ADDR_BITS:0]  rom_addr;
  logic [SNW-1:0]      rom_data;
  logic                s1_v_r;
  logic                s1_neg_r;
  logic [SQW-1:0]      s1_sq_r;
  logic                s2_v_r;
  logic                s2_neg_r;
  logic [SQW-1:0]      s2_sq_r;
  logic [PRW-1:0]      s2_prod_r;
  logic                div_valid;
  logic [DW-1:0]       div_quo;
  logic                div_neg;
  logic                div_busy;
  logic [ACW-1:0]      acc_r;
  logic                acc_neg;
  logic [ACW-1:0]      acc_mag;
  logic [ACW:0]        rnd_sum;
  logic [RW-1:0]       rounded;
  logic                clip;
  logic [SAMPLE_W-1:0] sample_val;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_clipped_r;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r      <= atws_pkg::AMP_RESET;
      phase_step_r     <= atws_pkg::STEP_RESET;
      harmonic_count_r <= atws_pkg::HCOUNT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        atws_pkg::CFG_AMPLITUDE:      amplitude_r      <= cfg_data[AW_-1:0];
        atws_pkg::CFG_PHASE_STEP:     phase_step_r     <= cfg_data[PW-1:0];
        atws_pkg::CFG_HARMONIC_COUNT: harmonic_count_r <= cfg_data[HCW-1:0];
        default: ;
      endcase
    end
  end

  // base phase: restart clears it for this item, then it advances
  assign start_phase = in_restart ? '0 : base_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_phase_r <= '0;
    end else if (cmd.start) begin
      base_phase_r <= start_phase + phase_step_r;
    end
  end

  // harmonic count limited to the built maximum
  assign count_clamp = (32'(harmonic_count_r) > MAX_H) ? HCW'(MAX_H) : harmonic_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd.start) begin
      rem_r <= count_clamp;
    end else if (cmd.issue) begin
      rem_r <= rem_r - HCW'(1);
    end
  end

  // harmonic generator: phase steps by twice the base, (i+2)^2 = i^2 + 4i + 4
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hp_r    <= start_phase;
      step2_r <= {start_phase[PW-2:0], 1'b0};
      i_r     <= IW'(1);
      sq_r    <= SQW'(1);
      kodd_r  <= 1'b0;
    end else if (cmd.issue) begin
      hp_r    <= hp_r + step2_r;
      i_r     <= i_r + IW'(2);
      sq_r    <= sq_r + SQW'({i_r, 2'b00}) + SQW'(4);
      kodd_r  <= ~kodd_r;
    end
  end

  // quarter-wave address: odd quadrants read mirrored
  assign rom_j    = hp_r[PW-3 -: ADDR_BITS];
  assign rom_addr = hp_r[PW-2] ? (QUARTER - {1'b0, rom_j}) : {1'b0, rom_j};

  atws_sine_rom #(
    .ADDR_BITS (ADDR_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // stage 1: rom read in flight, sign is lower half xor alternating harmonic sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_neg_r <= hp_r[PW-1] ^ kodd_r;
    s1_sq_r  <= sq_r;
  end

  // stage 2: gain times sine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_neg_r  <= s1_neg_r;
    s2_sq_r   <= s1_sq_r;
    s2_prod_r <= PRW'(amplitude_r) * PRW'(rom_data);
  end

  // divide by i^2
  atws_div #(
    .DVD_W (DW),
    .DVS_W (SQW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_dvd    (s2_prod_r[PRW-1:SHIFT]),
    .in_dvs    (s2_sq_r),
    .in_neg    (s2_neg_r),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_neg   (div_neg),
    .busy      (div_busy)
  );

  // signed accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (div_valid) begin
      acc_r <= div_neg ? (acc_r - ACW'(div_quo)) : (acc_r + ACW'(div_quo));
    end
  end

  // round magnitude half away from zero, then saturate
  always_comb begin
    acc_neg = acc_r[ACW-1];
    acc_mag = acc_neg ? (~acc_r + ACW'(1)) : acc_r;
    rnd_sum = {1'b0, acc_mag} + ROUND_HALF;
    rounded = rnd_sum[ACW:GB];
    if (acc_neg) begin
      clip       = (rounded > NEG_LIM);
      sample_val = clip ? SAT_MIN : (~rounded[SAMPLE_W-1:0] + SAMPLE_W'(1));
    end else begin
      clip       = (rounded > POS_LIM);
      sample_val = clip ? SAT_MAX : rounded[SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r  <= sample_val;
      out_clipped_r <= clip;
    end
  end

  assign out_sample  = out_sample_r;
  assign out_clipped = out_clipped_r;

  assign status.terms_left = (rem_r != '0);
  assign status.pipe_busy  = s1_v_r | s2_v_r | div_busy;

endmodule

[hw/rtl/atws_ctrl.sv]
// controller: item sequencing and handshakes
`timescale 1ns / 1ps

module atws_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  atws_pkg::dp_status_t status,
  output atws_pkg::dp_cmd_t    cmd
);

  atws_pkg::state_t state_r;
  atws_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  // output register can take a new sample
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atws_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = atws_pkg::ST_RUN;
        end
      end
      atws_pkg::ST_RUN: begin
        if (!status.terms_left && !status.pipe_busy) begin
          state_nxt = atws_pkg::ST_FINISH;
        end
      end
      atws_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = atws_pkg::ST_IDLE;
        end
      end
      default: state_nxt = atws_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd.start    = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      atws_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      atws_pkg::ST_RUN: begin
        cmd.issue = status.terms_left;
      end
      atws_pkg::ST_FINISH: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  // result valid flag
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atws_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hw/rtl/additive_triangle_wave_synth_top.sv]
// Additive triangle wave synthesizer, top level.
// Each input item (in_restart) makes one signed sample on out_sample, with
// out_clipped set when the rounded sum fell outside the sample range.
// in_restart = 1 zeroes the base phase for this sample.
// Registers on the cfg channel: 0 amplitude, 1 phase step, 2 harmonic count;
// cfg_ready is always high, other indexes are dropped. Write only while idle.
// One odd harmonic enters the term pipeline per clock: quarter-wave rom read,
// gain multiply, then a divider by i^2 with one stage per quotient bit
// (SAMPLE_BITS + 8 stages). The harmonic count N is limited to MAX_HARMONICS; once
// all N terms have left the divider, the rounded sum is loaded into the output
// register and out_valid rises. One item is worked on at a time.
// A new item is accepted as soon as the previous one sits in the output
// register; if the receiver stalls, the finished sum waits until the output
// register frees. Reset loads the register defaults and clears the base phase.
`timescale 1ns / 1ps

module additive_triangle_wave_synth_top #(
  parameter int MAX_HARMONICS        = atws_pkg::MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_ADDR_BITS = atws_pkg::SINE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS          = atws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [atws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atws_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   out_sample,
  output logic                            out_clipped
);

  atws_pkg::dp_cmd_t    cmd;
  atws_pkg::dp_status_t status;

  // registers are always writable
  assign cfg_ready = 1'b1;

  atws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  atws_datapath #(
    .MAX_H     (MAX_HARMONICS),
    .ADDR_BITS (SINE_TABLE_ADDR_BITS),
    .SAMPLE_W  (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_restart  (in_restart),
    .cmd         (cmd),
    .status      (status),
    .out_sample  (out_sample),
    .out_clipped (out_clipped)
  );

endmodule

[dv/tb.sv]
// testbench for the additive triangle wave synthesizer top level
`timescale 1ns / 1ps

module tb;

  localparam int ADDR_BITS   = atws_pkg::SINE_ADDR_BITS_DEF;
  localparam int SMP_BITS    = atws_pkg::SAMPLE_BITS_DEF;
  localparam int MAX_HARM    = atws_pkg::MAX_HARMONICS_DEF;
  localparam int ROM_LAST    = 1 << ADDR_BITS;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int PHASES_PER_MODE = 6;
  localparam int SETTLE_CYCLES   = MAX_HARM + SMP_BITS + 64;
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam bit [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  localparam bit [63:0] Q30_ONE     = 64'd1 << 30;
  localparam longint SAMPLE_MAX = (longint'(1) << (SMP_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // index that maps to no register
  localparam logic [atws_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SMP_BITS-1:0] sample;
    logic                       clipped;
  } synth_out_t;

  // dut ports
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [atws_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [atws_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_restart = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic signed [SMP_BITS-1:0]      out_sample;
  logic                            out_clipped;

  // synth model state and registers
  bit [30:0]                   sine_rom [0:ROM_LAST];
  bit [63:0]                   series_div [0:6] = '{210, 156, 110, 72, 42, 20, 6};
  bit [atws_pkg::AMP_W-1:0]    gain;
  bit [atws_pkg::PHASE_W-1:0]  phase_incr;
  bit [atws_pkg::HCOUNT_W-1:0] harmonics;
  bit [atws_pkg::PHASE_W-1:0]  phase_acc;

  synth_out_t pending_samples [$];
  synth_out_t oldest;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int errors = 0;
  int ticks_sent = 0;
  int samples_checked = 0;
  int clip_count = 0;
  int restart_count = 0;
  int cycle_count = 0;

  additive_triangle_wave_synth_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .out_clipped (out_clipped)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // quarter-wave sine in q1.30 from a truncated taylor series
  function automatic void build_sine_rom();
    bit [63:0] x, x2, r, t, s;
    for (int j = 0; j <= ROM_LAST; j++) begin
      x  = ((HALF_PI_Q60 >> 16) * 64'(j)) >> (ADDR_BITS + 14);
      x2 = (x * x) >> 30;
      r  = Q30_ONE;
      for (int d = 0; d < 7; d++) begin
        t = ((x2 * r) >> 30) / series_div[d];
        r = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
      end
      s = (x * r) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      sine_rom[j] = s[30:0];
    end
  endfunction

  // sum of odd harmonics for one tick, then advance the base phase
  function automatic synth_out_t synth_sample(input logic restart);
    bit [63:0] harm, prod, term, mag, rounded;
    bit [31:0] p;
    bit [ADDR_BITS-1:0] idx;
    bit [30:0] entry;
    int unsigned count;
    longint acc, val;
    bit neg;
    synth_out_t res;
    if (restart) phase_acc = '0;
    count = (harmonics > MAX_HARM) ? MAX_HARM : harmonics;
    acc = 0;
    for (int unsigned k = 0; k < count; k++) begin
      harm  = 64'(2 * k + 1);
      prod  = {32'b0, phase_acc} * harm;
      p     = prod[31:0];
      idx   = p[29 -: ADDR_BITS];
      entry = p[30] ? sine_rom[ROM_LAST - idx] : sine_rom[idx];
      term  = (({48'b0, gain} * {33'b0, entry}) >> (atws_pkg::TERM_SHIFT_BASE - SMP_BITS))
              / (harm * harm);
      // sine sign flipped on every other harmonic
      if (p[31] ^ k[0]) acc -= longint'(term);
      else acc += longint'(term);
    end
    // round half away from zero, then saturate
    neg = acc < 0;
    mag = neg ? 64'(-acc) : 64'(acc);
    rounded = (mag + (64'd1 << (atws_pkg::GUARD_BITS - 1))) >> atws_pkg::GUARD_BITS;
    val = neg ? -longint'(rounded) : longint'(rounded);
    res.clipped = 1'b0;
    if (val > SAMPLE_MAX) begin
      val = SAMPLE_MAX;
      res.clipped = 1'b1;
    end else if (val < SAMPLE_MIN) begin
      val = SAMPLE_MIN;
      res.clipped = 1'b1;
    end
    res.sample = val[SMP_BITS-1:0];
    phase_acc = phase_acc + phase_incr;
    return res;
  endfunction

  // track register writes and predict each accepted tick
  always @(posedge clk) begin
    if (!rst_n) begin
      gain       = atws_pkg::AMP_RESET;
      phase_incr = atws_pkg::STEP_RESET;
      harmonics  = atws_pkg::HCOUNT_RESET;
      phase_acc  = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          atws_pkg::CFG_AMPLITUDE:      gain = cfg_data[atws_pkg::AMP_W-1:0];
          atws_pkg::CFG_PHASE_STEP:     phase_incr = cfg_data[atws_pkg::PHASE_W-1:0];
          atws_pkg::CFG_HARMONIC_COUNT: harmonics = cfg_data[atws_pkg::HCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_samples.push_back(synth_sample(in_restart));
        ticks_sent++;
        if (in_restart) restart_count++;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // compare each sample with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample, expected none, got %0d clipped %0b",
                 $time, out_sample, out_clipped);
      end else begin
        oldest = pending_samples.pop_front();
        samples_checked++;
        if (out_clipped) clip_count++;
        if (out_sample !== oldest.sample) begin
          errors++;
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, oldest.sample, out_sample);
        end
        if (out_clipped !== oldest.clipped) begin
          errors++;
          $display("%0t: clipped mismatch, expected %0b, got %0b",
                   $time, oldest.clipped, out_clipped);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d samples outstanding",
               $time, cycle_count, pending_samples.size());
      $display("status: fail");
      $finish;
    end
  end

  // one register write, with cfg_valid dropped after it
  task automatic write_reg(input logic [atws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [atws_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one tick item; valid stays up after acceptance until the next call
  task automatic send_tick(input logic restart);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every predicted sample has come back
  task automatic drain_samples();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // reset register values, restart on the first and fourth items
  task automatic test_reset_defaults();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_samples();
  endtask

  // zero harmonics, single harmonic, counts beyond the maximum
  task automatic test_harmonic_limits();
    write_reg(atws_pkg::CFG_HARMONIC_COUNT, 32'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_samples();
    write_reg(atws_pkg::CFG_HARMONIC_COUNT, 32'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_samples();
    write_reg(atws_pkg::CFG_HARMONIC_COUNT, 32'hFFFF_FFFF);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_samples();
    write_reg(atws_pkg::CFG_HARMONIC_COUNT, 32'd513);
    send_tick(1'b0);
    drain_samples();
  endtask

  // full gain at quarter-turn steps: peaks clip in both directions
  task automatic test_quadrant_peaks();
    write_reg(atws_pkg::CFG_AMPLITUDE, 32'h0000_FFFF);
    write_reg(atws_pkg::CFG_PHASE_STEP, 32'h4000_0000);
    write_reg(atws_pkg::CFG_HARMONIC_COUNT, MAX_HARM);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    drain_samples();
  endtask

  // unused index, zero gain, data bits above the register width, step extremes
  task automatic test_register_edges();
    write_reg(CFG_IDX_UNUSED, 32'h0000_0000);
    write_reg(atws_pkg::CFG_AMPLITUDE, 32'h0000_0000);
    send_tick(1'b1);
    drain_samples();
    write_reg(atws_pkg::CFG_AMPLITUDE, 32'hABCD_0001);
    write_reg(atws_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(atws_pkg::CFG_HARMONIC_COUNT, 32'h5A5A_0040);
    write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_samples();
    write_reg(atws_pkg::CFG_AMPLITUDE, 32'h0000_C000);
    write_reg(atws_pkg::CFG_PHASE_STEP, 32'h0000_0000);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_samples();
  endtask

  // random settings per phase; first phase of each run uses the largest counts
  task automatic test_random_stream(input int in_pct, input int out_pct);
    logic [atws_pkg::AMP_W-1:0]    amp;
    logic [atws_pkg::PHASE_W-1:0]  incr;
    logic [atws_pkg::HCOUNT_W-1:0] count;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
      amp   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      incr  = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 1 << 20))
                                          : 32'($urandom);
      count = (ph == 0) ? 10'($urandom_range(MAX_HARM, 1023))
                        : 10'($urandom_range(0, 40));
      write_reg(atws_pkg::CFG_AMPLITUDE, {16'($urandom), amp});
      write_reg(atws_pkg::CFG_PHASE_STEP, incr);
      write_reg(atws_pkg::CFG_HARMONIC_COUNT, {22'($urandom), count});
      repeat (ITEMS_PER_PHASE) send_tick($urandom_range(0, 9) == 0);
      drain_samples();
    end
  endtask

  initial begin
    build_sine_rom();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_harmonic_limits();
    test_quadrant_peaks();
    test_register_edges();
    test_random_stream(17, 61);
    test_random_stream(61, 17);
    test_random_stream(0, 0);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d ticks sent (%0d with restart), %0d samples checked",
             ticks_sent, restart_count, samples_checked);
    $display("summary: %0d clipped samples, %0d mismatches, %0d cycles",
             clip_count, errors, cycle_count);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
